// ----- rtl/rdp_pkg.sv -----
package rdp_pkg;

    localparam int MAX_ENTRIES = 512;
    localparam int LIMIT_W     = 21;
    localparam int INDEX_W     = 9;
    localparam int COUNT_W     = 10;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);

    localparam logic KIND_ENTRY   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_SHORT     = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic               kind;
        logic [INDEX_W-1:0] entry_index;
        logic [63:0]        name_low;
        logic [15:0]        name_high;
        logic [15:0]        ext_info;
        logic [31:0]        payload_size;
        logic [31:0]        payload_offset;
        logic [1:0]         status;
        logic [COUNT_W-1:0] entry_count;
        logic               last_result;
    } out_item_t;

    // up to two results from one byte, first goes out first
    typedef struct packed {
        logic [1:0] count;
        out_item_t  first;
        out_item_t  second;
    } push_t;

endpackage

// ----- rtl/rom_directory_parser_core.sv -----
// rom directory parser
// in channel (in_valid/in_ready/in_data) takes the image one byte per request,
// with last_byte set on the final byte of an image.
// out channel (out_valid/out_ready/out_data) gives directory entries and, after
// the final byte, one summary; last_result marks the last result of a byte.
// cfg channel (cfg_valid/cfg_ready/cfg_data) writes scan_limit, always ready;
// write it only while no byte is in flight.
// latency: a byte accepted is held in the input register and then written into the
// result queue, whose head drives out_data.
// throughput: one byte per cycle while out_ready is held high; a final byte
// that brings an entry and the summary puts two results in the queue.
// results wait in a four-deep queue; once it cannot take two more, the byte in
// the input register is held until there is room, and in_ready drops meanwhile.
// reset: scan_limit returns to 65536 and the parser starts a new image;
// after every final byte the image state clears again, scan_limit is kept.
module rom_directory_parser_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  rdp_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output rdp_pkg::out_item_t            out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rdp_pkg::LIMIT_W-1:0]   cfg_data
);
    import rdp_pkg::*;

    logic                 in_valid_reg;
    in_item_t             in_item_reg;
    logic [LIMIT_W-1:0]   scan_limit_reg;
    logic                 room;
    logic                 fire;
    push_t                push;

    assign cfg_ready = 1'b1;
    assign fire      = in_valid_reg && room;
    assign in_ready  = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            scan_limit_reg <= LIMIT_W'(65536);
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                scan_limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg <= in_data;
        end
    end

    rdp_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .item       (in_item_reg),
        .scan_limit (scan_limit_reg),
        .push       (push)
    );

    rdp_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .room      (room)
    );

endmodule

// ----- rtl/rdp_parser.sv -----
module rdp_parser (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  rdp_pkg::in_item_t             item,
    input  logic [rdp_pkg::LIMIT_W-1:0]   scan_limit,
    output rdp_pkg::push_t                push
);
    import rdp_pkg::*;

    localparam int WIN_LEN = 22;
    localparam int ENT_LEN = 16;

    localparam logic [1:0] PH_SEARCH = 2'd0;
    localparam logic [1:0] PH_PARSE  = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;

    localparam logic [7:0] SIG_RESET [0:9] = '{
        8'h52, 8'h45, 8'h53, 8'h45, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };
    localparam logic [7:0] SIG_ROMDIR [0:5] = '{
        8'h52, 8'h4F, 8'h4D, 8'h44, 8'h49, 8'h52
    };

    logic [7:0]         win_reg [0:WIN_LEN-1];
    logic [7:0]         win_next [0:WIN_LEN-1];
    logic [7:0]         buf_reg [0:ENT_LEN-1];
    logic [7:0]         buf_next [0:ENT_LEN-1];
    logic [31:0]        pos_reg;
    logic [31:0]        pos_next;
    logic [1:0]         phase_reg;
    logic [1:0]         phase_next;
    logic [3:0]         fill_reg;
    logic [3:0]         fill_next;
    logic [31:0]        offset_reg;
    logic [31:0]        offset_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    logic [7:0]         ent [0:ENT_LEN-1];
    logic               sig_hit;
    logic               pos_ok;
    logic               searching;
    logic               parsing;
    logic               search_hit;
    logic               entry_go;
    logic               is_term;
    logic               emit;
    logic [15:0]        ext;
    logic [31:0]        size;
    logic [COUNT_W-1:0] count_inc;
    logic [1:0]         phase_after;
    logic [1:0]         status;
    out_item_t          entry_res;
    out_item_t          sum_res;

    always_comb
    begin
        for (int i = 0; i < WIN_LEN - 1; i++)
        begin
            win_next[i] = win_reg[i+1];
        end
        win_next[WIN_LEN-1] = item.data_byte;

        sig_hit = 1'b1;
        for (int i = 0; i < 10; i++)
        begin
            if (win_next[i] != SIG_RESET[i])
            begin
                sig_hit = 1'b0;
            end
        end
        for (int i = 0; i < 6; i++)
        begin
            if (win_next[ENT_LEN+i] != SIG_ROMDIR[i])
            begin
                sig_hit = 1'b0;
            end
        end

        // signature start is pos - 21, it counts if start + 10 <= scan_limit
        pos_ok = (pos_reg >= 32'd21)
              && ((pos_reg - 32'd11) <= {{(32-LIMIT_W){1'b0}}, scan_limit});

        searching  = (phase_reg == PH_SEARCH);
        parsing    = (phase_reg == PH_PARSE);
        search_hit = searching && pos_ok && sig_hit;
        entry_go   = search_hit || (parsing && (fill_reg == 4'd15));

        for (int i = 0; i < ENT_LEN; i++)
        begin
            if (searching)
            begin
                ent[i] = win_next[i];
            end
            else if (i == ENT_LEN - 1)
            begin
                ent[i] = item.data_byte;
            end
            else
            begin
                ent[i] = buf_reg[i];
            end
        end

        ext     = {ent[11], ent[10]};
        size    = {ent[15], ent[14], ent[13], ent[12]};
        is_term = (ent[0] == 8'h00) && (ext == 16'h0000) && (size == 32'h0);
        emit    = entry_go && !is_term;

        count_inc = count_reg + COUNT_W'(1);

        phase_after = phase_reg;
        if (entry_go)
        begin
            if (is_term || (count_inc >= COUNT_W'(MAX_ENTRIES)))
            begin
                phase_after = PH_DONE;
            end
            else
            begin
                phase_after = PH_PARSE;
            end
        end

        buf_next  = buf_reg;
        fill_next = fill_reg;
        if (search_hit && (phase_after == PH_PARSE))
        begin
            for (int i = 0; i < 6; i++)
            begin
                buf_next[i] = win_next[ENT_LEN+i];
            end
            fill_next = 4'd6;
        end
        else if (parsing)
        begin
            buf_next[fill_reg] = item.data_byte;
            fill_next          = fill_reg + 4'd1;
        end

        offset_next = emit ? (offset_reg + ((size + 32'd15) & ~32'd15)) : offset_reg;
        count_next  = emit ? count_inc : count_reg;
        pos_next    = (pos_reg == 32'hFFFF_FFFF) ? pos_reg : (pos_reg + 32'd1);

        priority if (pos_next < 32'd32)
        begin
            status = STATUS_SHORT;
        end
        else if (phase_after == PH_SEARCH)
        begin
            status = STATUS_NOT_FOUND;
        end
        else
        begin
            status = STATUS_OK;
        end

        entry_res                = '0;
        entry_res.kind           = KIND_ENTRY;
        entry_res.entry_index    = count_reg[INDEX_W-1:0];
        entry_res.name_low       = {ent[7], ent[6], ent[5], ent[4],
                                    ent[3], ent[2], ent[1], ent[0]};
        entry_res.name_high      = {ent[9], ent[8]};
        entry_res.ext_info       = ext;
        entry_res.payload_size   = size;
        entry_res.payload_offset = offset_reg;
        entry_res.last_result    = !item.last_byte;

        sum_res             = '0;
        sum_res.kind        = KIND_SUMMARY;
        sum_res.status      = status;
        sum_res.entry_count = count_next;
        sum_res.last_result = 1'b1;

        push.count  = fire ? ({1'b0, emit} + {1'b0, item.last_byte}) : 2'd0;
        push.first  = emit ? entry_res : sum_res;
        push.second = sum_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN_LEN; i++)
            begin
                win_reg[i] <= 8'h00;
            end
            pos_reg    <= '0;
            phase_reg  <= PH_SEARCH;
            fill_reg   <= '0;
            offset_reg <= '0;
            count_reg  <= '0;
        end
        else if (fire)
        begin
            if (item.last_byte)
            begin
                // image done, start the next one from scratch
                for (int i = 0; i < WIN_LEN; i++)
                begin
                    win_reg[i] <= 8'h00;
                end
                pos_reg    <= '0;
                phase_reg  <= PH_SEARCH;
                fill_reg   <= '0;
                offset_reg <= '0;
                count_reg  <= '0;
            end
            else
            begin
                win_reg    <= win_next;
                pos_reg    <= pos_next;
                phase_reg  <= phase_after;
                fill_reg   <= fill_next;
                offset_reg <= offset_next;
                count_reg  <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            buf_reg <= buf_next;
        end
    end

endmodule

// ----- rtl/rdp_out_fifo.sv -----
module rdp_out_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  rdp_pkg::push_t     push,
    input  logic               out_ready,
    output logic               out_valid,
    output rdp_pkg::out_item_t out_data,
    output logic               room
);
    import rdp_pkg::*;

    out_item_t             mem [0:FIFO_DEPTH-1];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_next;
    logic [FIFO_PTR_W:0]   count_reg;
    logic [FIFO_PTR_W:0]   count_next;
    logic                  pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    // one byte can bring two results
    assign room      = (count_reg <= (FIFO_PTR_W+1)'(FIFO_DEPTH - 2));
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
        count_next  = count_reg + (FIFO_PTR_W+1)'(push.count)
                    - (FIFO_PTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_reg + FIFO_PTR_W'(1)] <= push.second;
        end
    end

endmodule

// ----- sim/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rdp_pkg::*;

    // "RESET" and five zero bytes, first byte in the low bits
    localparam bit [79:0] RESET_NAME = 80'h0000000000_5445534552;
    // "ROMDIR", first byte in the low bits
    localparam bit [47:0] ROMDIR_TAG = 48'h5249444D4F52;

    typedef enum logic [1:0] {
        SCAN_SEARCH,
        SCAN_PARSE,
        SCAN_DONE
    } scan_phase_e;

    class dir_scoreboard;
        bit [175:0]         window;
        bit [31:0]          position;
        scan_phase_e        phase;
        bit [127:0]         entry_bytes;
        int unsigned        entry_fill;
        bit [31:0]          offset_sum;
        int unsigned        emitted;
        bit [LIMIT_W-1:0]   scan_limit;
        out_item_t          pending_records[$];
        int                 mismatches;

        function new();
            scan_limit   = 21'd65536;
            mismatches   = 0;
            restart_image();
        endfunction

        function void restart_image();
            window      = '0;
            position    = '0;
            phase       = SCAN_SEARCH;
            entry_bytes = '0;
            entry_fill  = 0;
            offset_sum  = '0;
            emitted     = 0;
        endfunction

        // decodes one 16-byte entry, gives 0 for a terminator
        function bit take_entry(bit [127:0] e, output out_item_t rec);
            rec = '0;
            if (e[7:0] == 8'd0 && e[95:80] == 16'd0 && e[127:96] == 32'd0)
            begin
                phase = SCAN_DONE;
                return 1'b0;
            end
            rec.kind           = KIND_ENTRY;
            rec.entry_index    = emitted[INDEX_W-1:0];
            rec.name_low       = e[63:0];
            rec.name_high      = e[79:64];
            rec.ext_info       = e[95:80];
            rec.payload_size   = e[127:96];
            rec.payload_offset = offset_sum;
            offset_sum = offset_sum + ((e[127:96] + 32'd15) & ~32'd15);
            emitted++;
            phase = (emitted >= MAX_ENTRIES) ? SCAN_DONE : SCAN_PARSE;
            return 1'b1;
        endfunction

        function void note_byte(in_item_t item);
            out_item_t recs[$];
            out_item_t rec;
            bit [31:0] seen;
            seen = position;
            window = {item.data_byte, window[175:8]};
            if (phase == SCAN_SEARCH) begin
                // window holds bytes seen-21 .. seen
                if (seen >= 32'd21 && seen - 32'd11 <= {11'd0, scan_limit} &&
                    window[79:0] == RESET_NAME && window[175:128] == ROMDIR_TAG)
                begin
                    if (take_entry(window[127:0], rec))
                        recs.push_back(rec);
                    if (phase == SCAN_PARSE) begin
                        entry_bytes[47:0] = window[175:128];
                        entry_fill = 6;
                    end
                end
            end
            else if (phase == SCAN_PARSE) begin
                entry_bytes[8*entry_fill +: 8] = item.data_byte;
                entry_fill++;
                if (entry_fill >= 16) begin
                    entry_fill = 0;
                    if (take_entry(entry_bytes, rec))
                        recs.push_back(rec);
                end
            end
            if (position != 32'hFFFF_FFFF)
                position++;
            if (item.last_byte) begin
                rec = '0;
                rec.kind = KIND_SUMMARY;
                if (position < 32'd32)
                    rec.status = STATUS_SHORT;
                else if (phase == SCAN_SEARCH)
                    rec.status = STATUS_NOT_FOUND;
                else
                    rec.status = STATUS_OK;
                rec.entry_count = emitted[COUNT_W-1:0];
                recs.push_back(rec);
                restart_image();
            end
            if (recs.size() > 0) begin
                rec = recs.pop_back();
                rec.last_result = 1'b1;
                recs.push_back(rec);
            end
            foreach (recs[i])
                pending_records.push_back(recs[i]);
        endfunction

        function void compare_field(string field, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                mismatches++;
                $display("%0t ns: %s mismatch, expected %0h, got %0h",
                         $time, field, want, got);
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (pending_records.size() == 0) begin
                mismatches++;
                $display("%0t ns: result with none pending, got %h", $time, got);
                return;
            end
            want = pending_records.pop_front();
            compare_field("kind", 64'(want.kind), 64'(got.kind));
            compare_field("entry_index", 64'(want.entry_index), 64'(got.entry_index));
            compare_field("name_low", want.name_low, got.name_low);
            compare_field("name_high", 64'(want.name_high), 64'(got.name_high));
            compare_field("ext_info", 64'(want.ext_info), 64'(got.ext_info));
            compare_field("payload_size", 64'(want.payload_size), 64'(got.payload_size));
            compare_field("payload_offset", 64'(want.payload_offset),
                          64'(got.payload_offset));
            compare_field("status", 64'(want.status), 64'(got.status));
            compare_field("entry_count", 64'(want.entry_count), 64'(got.entry_count));
            compare_field("last_result", 64'(want.last_result), 64'(got.last_result));
        endfunction
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    in_item_t           in_data   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    out_item_t          out_data;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [LIMIT_W-1:0] cfg_data  = '0;

    dir_scoreboard board;
    bit [7:0]      image_q[$];
    int            bytes_sent = 0;
    bit            tx_gaps    = 1'b0;
    bit            rx_stalls  = 1'b0;

    rom_directory_parser_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int idle_gap(int zero_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < zero_pct)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic void put_bytes(bit [127:0] v, int n);
        for (int i = 0; i < n; i++)
            image_q.push_back(v[8*i +: 8]);
    endfunction

    function automatic void put_entry(bit [79:0] name, bit [15:0] ext, bit [31:0] size);
        put_bytes({size, ext, name}, 16);
    endfunction

    function automatic bit [79:0] random_name();
        bit [79:0] name;
        name[31:0]  = $urandom;
        name[63:32] = $urandom;
        name[79:64] = 16'($urandom);
        return name;
    endfunction

    function automatic bit [31:0] size_value();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'($urandom_range(0, 4095)) << 4;
            3: return 32'($urandom_range(1, 100));
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_prefix();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return $urandom_range(0, 9);
        if (r < 75)
            return $urandom_range(0, 24);
        if (r < 90) begin
            // straddle the limit: two starts allowed, one just too far
            if (board.scan_limit >= 11 && board.scan_limit <= 300)
                return int'(board.scan_limit) - 11 + $urandom_range(0, 2);
            return $urandom_range(0, 24);
        end
        return $urandom_range(25, 200);
    endfunction

    // random lead-in, signature, a few entries, then a terminator, a cut entry or nothing
    function automatic void build_directory(int prefix_len);
        bit [79:0] name;
        int        r;
        repeat (prefix_len)
            image_q.push_back(8'($urandom));
        put_entry(RESET_NAME, 16'($urandom), size_value());
        name = {32'd0, ROMDIR_TAG};
        if ($urandom_range(0, 1) != 0)
            name[79:48] = $urandom;
        put_entry(name, 16'($urandom), size_value());
        repeat ($urandom_range(0, 3)) begin
            name = random_name();
            if ($urandom_range(0, 5) == 0)
                name[7:0] = 8'd0;
            put_entry(name, 16'($urandom), size_value());
        end
        r = $urandom_range(0, 99);
        if (r < 40) begin
            name = random_name();
            name[7:0] = 8'd0;
            put_entry(name, 16'd0, 32'd0);
            repeat ($urandom_range(0, 8))
                image_q.push_back(8'($urandom));
        end
        else if (r < 70) begin
            repeat ($urandom_range(1, 15))
                image_q.push_back(8'($urandom));
        end
    endfunction

    task automatic send_byte(input in_item_t item);
        int gap;
        gap = tx_gaps ? idle_gap(60) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
        board.note_byte(item);
        bytes_sent++;
    endtask

    task automatic send_image();
        in_item_t item;
        foreach (image_q[i]) begin
            item.data_byte = image_q[i];
            item.last_byte = (i == image_q.size() - 1);
            send_byte(item);
        end
        image_q.delete();
    endtask

    task automatic send_random_image();
        int prefix;
        int r;
        int idx;
        int cut;
        r = $urandom_range(0, 99);
        prefix = pick_prefix();
        if (r < 80) begin
            build_directory(prefix);
            if (r >= 65) begin
                // break one byte of either signature
                idx = $urandom_range(0, 15);
                if (idx >= 10)
                    idx += 6;
                image_q[prefix + idx] ^= 8'($urandom_range(1, 255));
            end
            if ($urandom_range(0, 9) == 0) begin
                cut = prefix + 22 + $urandom_range(0, 9);
                while (image_q.size() > cut)
                    void'(image_q.pop_back());
            end
        end
        else begin
            cut = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 31) : $urandom_range(32, 80);
            repeat (cut)
                image_q.push_back(8'($urandom));
        end
        send_image();
    endtask

    // wait for every pending result, then let the pipeline go quiet
    task automatic settle();
        in_valid <= 1'b0;
        while (board.pending_records.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_scan_limit(input logic [LIMIT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.scan_limit = value;
    endtask

    initial begin
        int         target;
        board = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one-byte images, then a 22-byte image found at offset 0 (entry and summary at once)
        image_q.push_back(8'hFF);
        send_image();
        image_q.push_back(8'h00);
        send_image();
        put_entry(RESET_NAME, 16'hFFFF, 32'hFFFF_FFFF);
        put_bytes({80'd0, ROMDIR_TAG}, 6);
        send_image();

        for (int ph = 0; ph < 8; ph++) begin
            if (ph > 0) begin
                settle();
                case (ph)
                    1: write_scan_limit(21'd0);
                    2: write_scan_limit(21'd1048576);
                    3: write_scan_limit(21'($urandom_range(11, 60)));
                    4: write_scan_limit(21'($urandom_range(0, 1048576)));
                    5: write_scan_limit(21'($urandom_range(11, 200)));
                    6: write_scan_limit(21'd10);
                    default: write_scan_limit(21'd65536);
                endcase
            end
            tx_gaps   = (ph % 3 != 2);
            rx_stalls = (ph % 3 != 1);
            target = bytes_sent + 100;
            while (bytes_sent < target) begin
                send_random_image();
                if ($urandom_range(0, 19) == 0)
                    settle();
            end
        end

        settle();
        if (board.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // result side: take and check results, stall at random
    initial begin
        int stall_left;
        bit ready_next;
        stall_left = 0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (out_valid && out_ready)
                board.check_result(out_data);
            ready_next = 1'b1;
            if (stall_left > 0) begin
                ready_next = 1'b0;
                stall_left--;
            end
            else if (rx_stalls && $urandom_range(0, 99) < 20) begin
                stall_left = idle_gap(0) - 1;
                ready_next = 1'b0;
            end
            out_ready <= ready_next;
        end
    end

    initial begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
